// ----- sv/tkss_pkg.sv -----
`timescale 1ns / 1ps
package tkss_pkg;

  localparam int SCORE_W = 32;
  localparam int DOC_W   = 32;
  localparam int CMD_W   = 2;
  localparam int KEEP_W  = 11;
  localparam int ENT_W   = 11;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic REG_KEEP_COUNT = 1'b0;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 11'd1000;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [DOC_W-1:0]          doc;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_REP,
    OP_POP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   item;
  } cell_ctl_t;

  // a ranks nearer the minimum than b
  function automatic logic ranks_below(entry_t a, entry_t b);
    logic res;
    if (a.score != b.score) begin
      res = a.score < b.score;
    end else begin
      res = a.doc < b.doc;
    end
    return res;
  endfunction

endpackage

// ----- sv/tkss_cell.sv -----
`timescale 1ns / 1ps
module tkss_cell
  import tkss_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occ,
  input  entry_t    left_entry,
  input  logic      left_below,
  input  entry_t    right_entry,
  input  logic      right_below,
  output entry_t    entry,
  output logic      below
);

  entry_t entry_r;
  entry_t entry_nxt;

  // incoming item sorts at or before this slot (empty slots always)
  assign below = !occ || ranks_below(ctl.item, entry_r);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctl.op)
      OP_HOLD: entry_nxt = entry_r;
      OP_INS: begin
        if (below) begin
          entry_nxt = left_below ? left_entry : ctl.item;
        end
      end
      OP_REP: begin
        if (!right_below) begin
          entry_nxt = right_entry;
        end else if (!below) begin
          entry_nxt = ctl.item;
        end
      end
      OP_POP: entry_nxt = right_entry;
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ----- sv/top_k_score_selector.sv -----
`timescale 1ns / 1ps
// A pop's item is registered and appears on the out_ side in the cycle after it is accepted.
// Throughput: one command per cycle, held off only while a pop item waits on out_stall;
// the sorted cell row takes an insert, replace or pop without stalling.
// Reset: entry count cleared to zero and keep_count set to 1000; cell contents
// are left undefined and are only read once written.
module top_k_score_selector
  import tkss_pkg::*;
#(
  parameter int MAX_KEPT = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CMD_W-1:0]          in_command,
  input  logic signed [SCORE_W-1:0] in_score,
  input  logic [DOC_W-1:0]          in_doc_id,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [SCORE_W-1:0] out_score,
  output logic [DOC_W-1:0]          out_doc_id,
  output logic                      out_was_empty,
  output logic [ENT_W-1:0]          out_entries_left,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  localparam int FILL_W = $clog2(MAX_KEPT + 1);
  localparam int CMP_W  = (FILL_W > KEEP_W) ? FILL_W : KEEP_W;
  localparam int CAP_RESET = (1000 > MAX_KEPT) ? MAX_KEPT : 1000;

  logic [KEEP_W-1:0] keep_r;
  logic [FILL_W-1:0] cap_r;
  logic [FILL_W-1:0] cap_nxt;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;

  logic                      out_valid_r;
  logic signed [SCORE_W-1:0] out_score_r;
  logic [DOC_W-1:0]          out_doc_r;
  logic                      out_empty_r;
  logic [ENT_W-1:0]          out_left_r;

  logic      accept;
  logic      cfg_wr;
  logic      full;
  logic      is_pop;
  cell_ctl_t ctl;

  entry_t           cell_entry [MAX_KEPT];
  logic [MAX_KEPT:0] cell_below;
  entry_t           head;

  assign head     = cell_entry[0];
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = fill_r >= cap_r;
  assign is_pop   = accept && (in_command == CMD_POP);
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_KEEP_COUNT);

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_KEEP_COUNT) ? DATA_W'(keep_r) : '0;

  always_comb begin
    logic [CMP_W-1:0] keep_ext;
    keep_ext = CMP_W'(pwdata[KEEP_W-1:0]);
    if (keep_ext == '0) begin
      cap_nxt = FILL_W'(1);
    end else if (keep_ext > CMP_W'(MAX_KEPT)) begin
      cap_nxt = FILL_W'(MAX_KEPT);
    end else begin
      cap_nxt = FILL_W'(keep_ext);
    end
  end

  // command decode
  always_comb begin
    ctl.op   = OP_HOLD;
    ctl.item = '{score: in_score, doc: in_doc_id};
    fill_nxt = fill_r;
    if (accept) begin
      unique case (in_command)
        CMD_INSERT: begin
          if (!full) begin
            ctl.op   = OP_INS;
            fill_nxt = fill_r + FILL_W'(1);
          end else if ((fill_r != '0) && (in_score > head.score)) begin
            ctl.op = OP_REP;
          end
        end
        CMD_POP: begin
          if (fill_r != '0) begin
            ctl.op   = OP_POP;
            fill_nxt = fill_r - FILL_W'(1);
          end
        end
        CMD_CLEAR: fill_nxt = '0;
        default: fill_nxt = fill_r;
      endcase
    end
  end

  // sorted row of cells, minimum at index 0
  assign cell_below[0] = 1'b0;

  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    entry_t right_e;
    logic   right_b;
    if (i == MAX_KEPT - 1) begin : g_last
      assign right_e = cell_entry[i];
      assign right_b = 1'b1;
    end else begin : g_mid
      assign right_e = cell_entry[i+1];
      assign right_b = cell_below[i+2];
    end
    tkss_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (fill_r > FILL_W'(i)),
      .left_entry  ((i == 0) ? cell_entry[0] : cell_entry[(i == 0) ? 0 : i-1]),
      .left_below  (cell_below[i]),
      .right_entry (right_e),
      .right_below (right_b),
      .entry       (cell_entry[i]),
      .below       (cell_below[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r      <= KEEP_RESET;
      cap_r       <= FILL_W'(CAP_RESET);
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        keep_r <= pwdata[KEEP_W-1:0];
        cap_r  <= cap_nxt;
      end
      fill_r <= fill_nxt;
      if (is_pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_pop) begin
      if (fill_r == '0) begin
        out_score_r <= '0;
        out_doc_r   <= '0;
        out_empty_r <= 1'b1;
        out_left_r  <= '0;
      end else begin
        out_score_r <= head.score;
        out_doc_r   <= head.doc;
        out_empty_r <= 1'b0;
        out_left_r  <= ENT_W'(fill_nxt);
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_score        = out_score_r;
  assign out_doc_id       = out_doc_r;
  assign out_was_empty    = out_empty_r;
  assign out_entries_left = out_left_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(MAX_KEPT))
    else $error("entry count beyond store depth");

  a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cap_r != '0) && (cap_r <= FILL_W'(MAX_KEPT)))
    else $error("capacity out of range");

  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    is_pop |=> out_valid_r)
    else $error("pop gave no result");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (is_pop && (fill_r != '0)) |=> (fill_r == $past(fill_r) - FILL_W'(1)))
    else $error("pop did not remove one entry");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import tkss_pkg::*;

  localparam int MAX_KEPT = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0] KEEP_ADDR = {REG_KEEP_COUNT, 2'b00};

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [DOC_W-1:0]          doc;
    logic                      was_empty;
    logic [ENT_W-1:0]          left;
  } pop_result_t;

  localparam pop_result_t NO_POP = '0;
  localparam pop_result_t EMPTY_POP = pop_result_t'({32'd0, 32'd0, 1'b1, 11'd0});

  typedef enum { ROW_ITEM, ROW_KEEP } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [CMD_W-1:0]  cmd;
    logic [31:0]       score;
    logic [31:0]       doc;
    bit                typed;
    pop_result_t       res;
    logic [KEEP_W-1:0] keep;
  } dir_row_t;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [CMD_W-1:0]          in_command = '0;
  logic signed [SCORE_W-1:0] in_score = '0;
  logic [DOC_W-1:0]          in_doc_id = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [SCORE_W-1:0] out_score;
  logic [DOC_W-1:0]          out_doc_id;
  logic                      out_was_empty;
  logic [ENT_W-1:0]          out_entries_left;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [ADDR_W-1:0]         paddr = '0;
  logic [DATA_W-1:0]         pwdata = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  dir_row_t          dir_rows[$];
  pop_result_t       expected_pops[$];
  logic [31:0]       kept_score[MAX_KEPT];
  logic [31:0]       kept_doc[MAX_KEPT];
  int unsigned       held = 0;
  logic [KEEP_W-1:0] keep_model = KEEP_RESET;
  int unsigned       errors = 0;
  int unsigned       out_burst = 0;
  bit                idle_on = 1'b1;
  bit                typed_on = 1'b0;
  pop_result_t       typed_res = '0;

  top_k_score_selector #(.MAX_KEPT(MAX_KEPT)) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_score         (in_score),
    .in_doc_id        (in_doc_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_score        (out_score),
    .out_doc_id       (out_doc_id),
    .out_was_empty    (out_was_empty),
    .out_entries_left (out_entries_left),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  // lowest score wins, ties to the smallest doc id
  function automatic int unsigned min_slot();
    int unsigned best;
    best = 0;
    for (int unsigned i = 1; i < held; i++) begin
      if ($signed(kept_score[i]) < $signed(kept_score[best]) ||
          (kept_score[i] == kept_score[best] && kept_doc[i] < kept_doc[best])) begin
        best = i;
      end
    end
    return best;
  endfunction

  task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [31:0] sc,
                               input logic [31:0] doc, output bit has_res,
                               output pop_result_t res);
    int unsigned m;
    int unsigned cap;
    has_res = 1'b0;
    res = '0;
    cap = (keep_model == 0) ? 1 : (keep_model > MAX_KEPT) ? MAX_KEPT : keep_model;
    case (cmd)
      CMD_INSERT: begin
        if (held < cap) begin
          kept_score[held] = sc;
          kept_doc[held] = doc;
          held++;
        end else if (held > 0) begin
          m = min_slot();
          if ($signed(sc) > $signed(kept_score[m])) begin
            kept_score[m] = sc;
            kept_doc[m] = doc;
          end
        end
      end
      CMD_POP: begin
        has_res = 1'b1;
        if (held == 0) begin
          res.was_empty = 1'b1;
        end else begin
          m = min_slot();
          res.score = kept_score[m];
          res.doc = kept_doc[m];
          kept_score[m] = kept_score[held-1];
          kept_doc[m] = kept_doc[held-1];
          held--;
          res.left = held[ENT_W-1:0];
        end
      end
      CMD_CLEAR: held = 0;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    bit has_res;
    pop_result_t res;
    pop_result_t want;
    if (rst_n && in_valid && !in_stall) begin
      apply_command(in_command, in_score, in_doc_id, has_res, res);
      if (has_res) expected_pops.insert(expected_pops.size(), typed_on ? typed_res : res);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pops.size() == 0) begin
        report_mismatch("pop item with none expected", out_doc_id, 32'd0);
      end else begin
        want = expected_pops.pop_front();
        if (out_score !== want.score) report_mismatch("out_score", out_score, want.score);
        if (out_doc_id !== want.doc) report_mismatch("out_doc_id", out_doc_id, want.doc);
        if (out_was_empty !== want.was_empty) begin
          report_mismatch("out_was_empty", 32'(out_was_empty), 32'(want.was_empty));
        end
        if (out_entries_left !== want.left) begin
          report_mismatch("out_entries_left", 32'(out_entries_left), 32'(want.left));
        end
      end
    end
  end

  always @(negedge clk) begin
    bit stall_next;
    stall_next = 1'b0;
    if (out_burst != 0) begin
      out_burst--;
      stall_next = 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_burst = $urandom_range(0, 16);
      stall_next = 1'b1;
    end
    out_stall <= stall_next;
  end

  function automatic logic [31:0] rand_score();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 4)) - 32'd2;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_doc();
    return ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
  endfunction

  function automatic void add_row(input row_kind_t k, input logic [CMD_W-1:0] c,
                                  input logic [31:0] s, input logic [31:0] d,
                                  input bit t, input pop_result_t r,
                                  input logic [KEEP_W-1:0] kc);
    dir_row_t row;
    row.kind = k;
    row.cmd = c;
    row.score = s;
    row.doc = d;
    row.typed = t;
    row.res = r;
    row.keep = kc;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [31:0] sc,
                          input logic [31:0] doc, input bit typed, input pop_result_t res);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_score <= sc;
    in_doc_id <= doc;
    typed_on <= typed;
    typed_res <= res;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_keep(input logic [KEEP_W-1:0] v);
    logic [DATA_W-1:0] rd;
    in_valid <= 1'b0;
    while (expected_pops.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= KEEP_ADDR;
    pwdata <= DATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    keep_model = v;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    if (rd !== DATA_W'(v)) report_mismatch("keep_count readback", rd, DATA_W'(v));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [CMD_W-1:0] cmd;
    int unsigned      pick;

    // reset capacity, extremes, ties, unused code, clear
    add_row(ROW_ITEM, CMD_POP, 32'h0, 32'h0, 1, EMPTY_POP, '0);
    add_row(ROW_ITEM, CMD_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, NO_POP, '0);
    add_row(ROW_ITEM, CMD_INSERT, 32'h8000_0000, 32'h0, 0, NO_POP, '0);
    add_row(ROW_ITEM, CMD_INSERT, 32'h0, 32'd5, 0, NO_POP, '0);
    add_row(ROW_ITEM, CMD_INSERT, 32'h0, 32'd3, 0, NO_POP, '0);
    add_row(ROW_ITEM, CMD_POP, 32'h0, 32'h0, 1,
            pop_result_t'({32'h8000_0000, 32'h0, 1'b0, 11'd3}), '0);
    add_row(ROW_ITEM, CMD_POP, 32'h0, 32'h0, 1,
            pop_result_t'({32'h0, 32'd3, 1'b0, 11'd2}), '0);
    add_row(ROW_ITEM, CMD_POP, 32'h0, 32'h0, 1,
            pop_result_t'({32'h0, 32'd5, 1'b0, 11'd1}), '0);
    add_row(ROW_ITEM, CMD_POP, 32'h0, 32'h0, 1,
            pop_result_t'({32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 11'd0}), '0);
    add_row(ROW_ITEM, CMD_POP, 32'h0, 32'h0, 1, EMPTY_POP, '0);
    add_row(ROW_ITEM, CMD_UNUSED, 32'h1234_5678, 32'd9, 0, NO_POP, '0);
    add_row(ROW_ITEM, CMD_INSERT, 32'hFFFF_FFFF, 32'd7, 0, NO_POP, '0);
    add_row(ROW_ITEM, CMD_CLEAR, 32'h0, 32'h0, 0, NO_POP, '0);
    add_row(ROW_ITEM, CMD_POP, 32'h0, 32'h0, 1, EMPTY_POP, '0);
    // zero capacity acts as one: replace only on a strictly greater score
    add_row(ROW_KEEP, CMD_INSERT, 32'h0, 32'h0, 0, NO_POP, 11'd0);
    add_row(ROW_ITEM, CMD_INSERT, 32'd10, 32'd1, 0, NO_POP, '0);
    add_row(ROW_ITEM, CMD_INSERT, 32'd20, 32'd2, 0, NO_POP, '0);
    add_row(ROW_ITEM, CMD_INSERT, 32'd20, 32'd0, 0, NO_POP, '0);
    add_row(ROW_ITEM, CMD_INSERT, 32'd5, 32'd3, 0, NO_POP, '0);
    add_row(ROW_ITEM, CMD_POP, 32'h0, 32'h0, 1,
            pop_result_t'({32'd20, 32'd2, 1'b0, 11'd0}), '0);
    // saturated capacity, then lowered below the fill
    add_row(ROW_KEEP, CMD_INSERT, 32'h0, 32'h0, 0, NO_POP, 11'd2047);
    add_row(ROW_ITEM, CMD_INSERT, 32'd1, 32'd1, 0, NO_POP, '0);
    add_row(ROW_ITEM, CMD_INSERT, 32'd2, 32'd2, 0, NO_POP, '0);
    add_row(ROW_ITEM, CMD_INSERT, 32'd3, 32'd3, 0, NO_POP, '0);
    add_row(ROW_KEEP, CMD_INSERT, 32'h0, 32'h0, 0, NO_POP, 11'd2);
    add_row(ROW_ITEM, CMD_INSERT, 32'd4, 32'd4, 0, NO_POP, '0);
    repeat (4) add_row(ROW_ITEM, CMD_POP, 32'h0, 32'h0, 0, NO_POP, '0);

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_KEEP) begin
        write_keep(dir_rows[i].keep);
      end else begin
        push_cmd(dir_rows[i].cmd, dir_rows[i].score, dir_rows[i].doc,
                 dir_rows[i].typed, dir_rows[i].res);
      end
    end

    // fill to the top, then keep replacing
    write_keep(11'd1025);
    repeat (MAX_KEPT + 6) push_cmd(CMD_INSERT, rand_score(), rand_doc(), 0, NO_POP);
    repeat (20) push_cmd(CMD_POP, rand_score(), rand_doc(), 0, NO_POP);

    for (int p = 0; p < 10; p++) begin
      if (p >= 8) idle_on = 1'b0;
      case ($urandom_range(0, 7))
        0: pick = 0;
        1: pick = 1;
        2: pick = 2;
        3: pick = 1024;
        4: pick = 2047;
        5: pick = 1000;
        default: pick = $urandom_range(1, 40);
      endcase
      if (p == 0) pick = 3;
      write_keep(pick[KEEP_W-1:0]);
      repeat (15) begin
        pick = $urandom_range(0, 99);
        if (pick < 58) cmd = CMD_INSERT;
        else if (pick < 88) cmd = CMD_POP;
        else if (pick < 92) cmd = CMD_CLEAR;
        else cmd = CMD_UNUSED;
        push_cmd(cmd, rand_score(), rand_doc(), 0, NO_POP);
      end
    end

    in_valid <= 1'b0;
    while (expected_pops.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
